[rtl/pq_adc_filtered_scorer_unit_defines.svh]
// ----------------------------------------------------------------------------
// PQ ADC scorer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PQ_ADC_FILTERED_SCORER_UNIT_DEFINES_SVH
`define PQ_ADC_FILTERED_SCORER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define PQADC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pqadc assertion failed: same-cycle check");

// Next-cycle implication, sampled on aclk and disabled during reset.
`define PQADC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pqadc assertion failed: next-cycle check");

// Next-cycle implication that is also checked while reset is asserted.
`define PQADC_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pqadc assertion failed: reset check");

`endif

[rtl/pqadc_pkg.sv]
// ----------------------------------------------------------------------------
// PQ ADC scorer package
// Payload types, stage records, codes and the saturating adder shared by the
// scorer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pqadc_pkg;

    // Field widths fixed by the interface.
    localparam int ID_W        = 24;
    localparam int SCORE_W     = 32;
    localparam int COUNT_W     = 24;
    localparam int GROUP_CNT_W = 6;
    localparam int TGROUP_W    = 5;
    localparam int CODE_W      = 8;
    localparam int CODE_EXT_W  = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [COUNT_W-1:0]     COUNT_MAX     = '1;
    localparam logic [GROUP_CNT_W-1:0] GROUPS_RESET  = 6'd8;
    localparam logic [ID_W-1:0]        THRESH_RESET  = '0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUPS_IN_USE    = 2'd1;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_BEGIN = 2'd1,
        OP_CODE  = 2'd2
    } pqadc_op_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [TGROUP_W-1:0]       table_group;
        logic [CODE_W-1:0]         code;
        logic signed [SCORE_W-1:0] value;
        logic signed [SCORE_W-1:0] cluster_score;
        logic [ID_W-1:0]           point_id;
        logic                      new_cluster;
    } pqadc_in_t;

    typedef struct packed {
        logic [ID_W-1:0]           result_id;
        logic signed [SCORE_W-1:0] result_score;
        logic [COUNT_W-1:0]        accepted_count;
    } pqadc_out_t;

    // Front end to accumulator: one decoded transaction.
    typedef struct packed {
        logic                      is_begin;
        logic                      is_code;
        logic                      last;
        logic                      accepted;
        logic                      new_cluster;
        logic [ID_W-1:0]           point_id;
        logic signed [SCORE_W-1:0] bias;
        logic signed [SCORE_W-1:0] cluster_score;
    } pqadc_stage_t;

    // Accumulator to output stage: a finished point before the bias add.
    typedef struct packed {
        logic [ID_W-1:0]           point_id;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] bias;
        logic [COUNT_W-1:0]        count;
    } pqadc_fin_t;

    // Signed add that clips to the 32-bit range.
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0]   sum;
        logic signed [SCORE_W-1:0] res;
        sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (sum[SCORE_W] != sum[SCORE_W-1]) begin
            res = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            res = sum[SCORE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/pqadc_lut_ram.sv]
// ----------------------------------------------------------------------------
// PQ ADC lookup table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pqadc_lut_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/pqadc_frontend.sv]
// ----------------------------------------------------------------------------
// PQ ADC scorer front end
// Holds the configuration registers and the point sequencer, decodes each
// input transaction into table writes, table reads and a stage record.
// ----------------------------------------------------------------------------
`default_nettype none

module pqadc_frontend #(
    parameter int MAX_GROUPS = 32,
    parameter int CODE_BITS  = 8,
    localparam int GROUP_BITS = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    localparam int ADDR_W     = GROUP_BITS + CODE_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  advance,
    input  wire logic                                  s_valid,
    input  wire pqadc_pkg::pqadc_in_t                  s_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pqadc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pqadc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                       mem_we,
    output logic [ADDR_W-1:0]                          mem_waddr,
    output logic [pqadc_pkg::SCORE_W-1:0]              mem_wdata,
    output logic                                       mem_re,
    output logic [ADDR_W-1:0]                          mem_raddr,
    output pqadc_pkg::pqadc_stage_t                    stage
);

    import pqadc_pkg::*;

    localparam logic [GROUP_CNT_W:0]   MAX_G     = (GROUP_CNT_W+1)'(MAX_GROUPS);
    localparam logic [GROUP_CNT_W-1:0] MAX_G_M1  = GROUP_CNT_W'(MAX_GROUPS - 1);
    localparam logic [GROUP_CNT_W:0]   ONE_G     = (GROUP_CNT_W+1)'(1);

    logic [ID_W-1:0]        threshold_reg;
    logic [GROUP_CNT_W-1:0] groups_reg;
    logic                   point_open_reg;
    logic                   point_open_next;
    logic [GROUP_CNT_W-1:0] group_cnt_reg;
    logic [GROUP_CNT_W-1:0] group_cnt_next;
    pqadc_stage_t           stage_reg;
    pqadc_stage_t           stage_next;

    logic                   accept;
    logic                   is_write;
    logic                   is_begin;
    logic                   is_code;
    logic [CODE_EXT_W-1:0]  code_ext;
    logic [CODE_BITS-1:0]   code_idx;
    logic [GROUP_CNT_W-1:0] tgroup_ext;
    logic                   tgroup_ok;
    logic [GROUP_CNT_W-1:0] group_idx;
    logic [GROUP_CNT_W-1:0] group_inc;
    logic [GROUP_CNT_W:0]   eff_groups;
    logic                   last_code;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_RESET;
            groups_reg    <= GROUPS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FILTER_THRESHOLD: threshold_reg <= cfg_data[ID_W-1:0];
                CFG_GROUPS_IN_USE:    groups_reg    <= cfg_data[GROUP_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Transaction decode.
    assign accept   = s_valid && advance;
    assign is_write = accept && (s_data.op == OP_WRITE);
    assign is_begin = accept && (s_data.op == OP_BEGIN);
    assign is_code  = accept && (s_data.op == OP_CODE) && point_open_reg;

    // Table addressing: code bits above the row size are dropped.
    assign code_ext   = CODE_EXT_W'(s_data.code);
    assign code_idx   = code_ext[CODE_BITS-1:0];
    assign tgroup_ext = GROUP_CNT_W'(s_data.table_group);
    assign tgroup_ok  = ((GROUP_CNT_W+1)'(s_data.table_group) < MAX_G);
    assign group_idx  = ({1'b0, group_cnt_reg} >= MAX_G) ? MAX_G_M1 : group_cnt_reg;

    assign mem_we    = is_write && tgroup_ok;
    assign mem_waddr = {tgroup_ext[GROUP_BITS-1:0], code_idx};
    assign mem_wdata = s_data.value;
    assign mem_re    = is_code;
    assign mem_raddr = {group_idx[GROUP_BITS-1:0], code_idx};

    // End of point: the group count reaches the effective group count.
    always_comb begin
        if (groups_reg == '0) begin
            eff_groups = ONE_G;
        end else if ({1'b0, groups_reg} > MAX_G) begin
            eff_groups = MAX_G;
        end else begin
            eff_groups = {1'b0, groups_reg};
        end
    end

    assign group_inc = group_idx + GROUP_CNT_W'(1);
    assign last_code = ({1'b0, group_inc} >= eff_groups) || (group_inc == '0);

    // Point sequencer.
    always_comb begin
        point_open_next = point_open_reg;
        group_cnt_next  = group_cnt_reg;
        if (is_begin) begin
            point_open_next = 1'b1;
            group_cnt_next  = '0;
        end else if (is_code) begin
            point_open_next = !last_code;
            group_cnt_next  = last_code ? '0 : group_inc;
        end
    end

    // Stage record for the accumulator.
    always_comb begin
        stage_next.is_begin      = is_begin;
        stage_next.is_code       = is_code;
        stage_next.last          = last_code;
        stage_next.accepted      = (s_data.point_id >= threshold_reg);
        stage_next.new_cluster   = s_data.new_cluster;
        stage_next.point_id      = s_data.point_id;
        stage_next.bias          = s_data.value;
        stage_next.cluster_score = s_data.cluster_score;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_open_reg <= 1'b0;
            group_cnt_reg  <= '0;
            stage_reg      <= '0;
        end else if (advance) begin
            point_open_reg <= point_open_next;
            group_cnt_reg  <= group_cnt_next;
            stage_reg      <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

[rtl/pqadc_accum.sv]
// ----------------------------------------------------------------------------
// PQ ADC scorer accumulator
// Adds each group's table value to the running score and counts accepted
// points; hands a finished point to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pqadc_accum (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  advance,
    input  wire pqadc_pkg::pqadc_stage_t               stage,
    input  wire logic [pqadc_pkg::SCORE_W-1:0]         rdata,
    output logic                                       fin_load,
    output pqadc_pkg::pqadc_fin_t                      fin
);

    import pqadc_pkg::*;

    logic signed [SCORE_W-1:0] running_score_reg;
    logic signed [SCORE_W-1:0] bias_reg;
    logic [ID_W-1:0]           id_reg;
    logic                      accepted_reg;
    logic [COUNT_W-1:0]        count_reg;

    logic signed [SCORE_W-1:0] score_next;
    logic [COUNT_W-1:0]        count_next;

    // One saturating add per code and a saturating count increment.
    assign score_next = sat_add(running_score_reg, rdata);
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    assign fin_load = advance && stage.is_code && stage.last && accepted_reg;

    always_comb begin
        fin.point_id = id_reg;
        fin.score    = score_next;
        fin.bias     = bias_reg;
        fin.count    = count_next;
    end

    // Point state: loaded by a begin transaction, updated by each code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_score_reg <= '0;
            bias_reg          <= '0;
            id_reg            <= '0;
            accepted_reg      <= 1'b0;
            count_reg         <= '0;
        end else if (advance) begin
            if (stage.is_begin) begin
                running_score_reg <= stage.cluster_score;
                bias_reg          <= stage.bias;
                id_reg            <= stage.point_id;
                accepted_reg      <= stage.accepted;
                if (stage.new_cluster) begin
                    count_reg <= '0;
                end
            end else if (stage.is_code) begin
                running_score_reg <= score_next;
                if (fin_load) begin
                    count_reg <= count_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/pqadc_out_stage.sv]
// ----------------------------------------------------------------------------
// PQ ADC scorer output stage
// Holding slot for a finished point, bias add and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pqadc_out_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   fin_load,
    input  wire pqadc_pkg::pqadc_fin_t  fin,
    output logic                        full,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output pqadc_pkg::pqadc_out_t       m_data
);

    import pqadc_pkg::*;

    logic       fin_valid_reg;
    pqadc_fin_t fin_reg;
    logic       m_valid_reg;
    pqadc_out_t m_data_reg;
    pqadc_out_t m_data_next;
    logic       out_load;

    // The slot moves into the result register when that register frees up.
    assign out_load = fin_valid_reg && (!m_valid_reg || m_ready);
    assign full     = fin_valid_reg && m_valid_reg;

    always_comb begin
        m_data_next.result_id      = fin_reg.point_id;
        m_data_next.result_score   = sat_add(fin_reg.score, fin_reg.bias);
        m_data_next.accepted_count = fin_reg.count;
    end

    // Holding slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (fin_load) begin
            fin_valid_reg <= 1'b1;
        end else if (out_load) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg <= fin;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/pq_adc_filtered_scorer_unit.sv]
// ----------------------------------------------------------------------------
// PQ ADC filtered scorer
// Product-quantization score engine: table load, per-point code streaming,
// id filtering and saturating Q16.16 score accumulation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Carries
//  s_       in         s_valid / s_ready    pqadc_in_t: table write, point begin, code
//  m_       out        m_valid / m_ready    pqadc_out_t: id, score, accepted count
//  cfg_     in         cfg_valid/cfg_ready  register index and write data
//
// One input transaction is taken per cycle while s_ready is high; a code needs
// one table read and one add. A point's last code goes through the table read,
// the accumulate into the holding slot and the bias add into the result register.
// Reset is synchronous, active low; it clears control state and loads the register
// defaults, and the table holds no defined contents until written.
// s_ready drops only while both the holding slot and the result register hold a
// result; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module pq_adc_filtered_scorer_unit #(
    parameter int MAX_GROUPS = 32,
    parameter int CODE_BITS  = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire pqadc_pkg::pqadc_in_t               s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output pqadc_pkg::pqadc_out_t                   m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pqadc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pqadc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import pqadc_pkg::*;

    localparam int GROUP_BITS = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int ADDR_W     = GROUP_BITS + CODE_BITS;
    localparam int DEPTH      = MAX_GROUPS * (2 ** CODE_BITS);

    logic               advance;
    logic               full;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [SCORE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [SCORE_W-1:0] mem_rdata;
    pqadc_stage_t       stage;
    logic               fin_load;
    pqadc_fin_t         fin;

    // The pipeline moves unless a result waits in both output registers.
    assign advance = !full;
    assign s_ready = advance;

    pqadc_frontend #(
        .MAX_GROUPS (MAX_GROUPS),
        .CODE_BITS  (CODE_BITS)
    ) u_frontend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .stage     (stage)
    );

    pqadc_lut_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SCORE_W)
    ) u_lut_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pqadc_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .stage    (stage),
        .rdata    (mem_rdata),
        .fin_load (fin_load),
        .fin      (fin)
    );

    pqadc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fin_load (fin_load),
        .fin      (fin),
        .full     (full),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

[rtl/pqadc_checker.sv]
// ----------------------------------------------------------------------------
// PQ ADC scorer port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pq_adc_filtered_scorer_unit_defines.svh"

module pqadc_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_ready,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire pqadc_pkg::pqadc_out_t              m_data
);

    // A stalled result transaction holds its payload.
    `PQADC_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Reset empties the result register.
    `PQADC_ASSERT_RESET(a_reset_clears, !aresetn, !m_valid)

    // Every result counts at least its own point.
    `PQADC_ASSERT_NOW(a_count_nonzero, m_valid, m_data.accepted_count != '0)

    // With no result waiting, input transactions are always taken.
    `PQADC_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

endmodule

bind pq_adc_filtered_scorer_unit pqadc_checker u_pqadc_checker (.*);

`default_nettype wire

[sim/pq_adc_score_checker.sv]
// ----------------------------------------------------------------------------
// PQ ADC scorer checker
// Watches the input, result and register channels of the scorer. It keeps its
// own copy of the lookup table, the point state and the registers, predicts
// the result of every point that passes the id filter, and compares each
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pq_adc_score_checker
    import pqadc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  pqadc_in_t              s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  pqadc_out_t             m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending_results
);

    localparam int     GROUP_LIMIT = 32;
    localparam int     ROW_BITS    = 8;
    localparam int     LUT_DEPTH   = GROUP_LIMIT << ROW_BITS;
    localparam longint SCORE_TOP   = 64'sd2147483647;
    localparam longint SCORE_FLOOR = -64'sd2147483648;

    // Shadow copy of the partial inner product table and the point state.
    logic signed [SCORE_W-1:0] lut [0:LUT_DEPTH-1];
    logic signed [SCORE_W-1:0] run_score;
    logic signed [SCORE_W-1:0] point_bias;
    logic [GROUP_CNT_W-1:0]    next_group;
    logic [ID_W-1:0]           point_id;
    logic                      point_passes;
    logic                      point_open;
    logic [COUNT_W-1:0]        accepted;
    logic [ID_W-1:0]           threshold;
    logic [GROUP_CNT_W-1:0]    groups_cfg;

    // Predicted results, oldest first.
    pqadc_out_t expected_scores [$];
    int         errors = 0;

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    // Signed add that clips at the 32-bit limits.
    function automatic logic signed [SCORE_W-1:0] clip_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        longint total;
        total = longint'(a) + longint'(b);
        if (total > SCORE_TOP) return SCORE_TOP[SCORE_W-1:0];
        if (total < SCORE_FLOOR) return SCORE_FLOOR[SCORE_W-1:0];
        return total[SCORE_W-1:0];
    endfunction

    // A register value of zero acts as one group, large values as the maximum.
    function automatic int active_groups();
        int g;
        g = groups_cfg;
        if (g == 0) g = 1;
        if (g > GROUP_LIMIT) g = GROUP_LIMIT;
        return g;
    endfunction

    task automatic report(input string what);
        $display("[%0t] scorer mismatch: %s", $time, what);
        errors++;
    endtask

    // Compare one result transaction with the oldest prediction.
    task automatic check_result(input pqadc_out_t got);
        pqadc_out_t want;
        if (expected_scores.size() == 0) begin
            report($sformatf("result id %06h arrived with no point pending", got.result_id));
        end else begin
            want = expected_scores.pop_front();
            if (got.result_id !== want.result_id)
                report($sformatf("id %06h, expected %06h", got.result_id, want.result_id));
            if (got.result_score !== want.result_score)
                report($sformatf("id %06h score %08h, expected %08h",
                                 want.result_id, got.result_score, want.result_score));
            if (got.accepted_count !== want.accepted_count)
                report($sformatf("id %06h count %0d, expected %0d",
                                 want.result_id, got.accepted_count, want.accepted_count));
        end
    endtask

    // Advance the shadow state by one input transaction.
    task automatic apply_item(input pqadc_in_t it);
        pqadc_out_t res;
        case (it.op)
            OP_WRITE: begin
                lut[{it.table_group, it.code}] = it.value;
            end
            OP_BEGIN: begin
                if (it.new_cluster) accepted = '0;
                point_id     = it.point_id;
                point_passes = (it.point_id >= threshold);
                point_bias   = it.value;
                run_score    = it.cluster_score;
                next_group   = '0;
                point_open   = 1'b1;
            end
            OP_CODE: begin
                if (point_open) begin
                    if (next_group >= GROUP_LIMIT) next_group = GROUP_LIMIT - 1;
                    run_score  = clip_add(run_score, lut[{next_group[4:0], it.code}]);
                    next_group = next_group + 1'b1;
                    // The point closes at its last group, or when the count was lowered.
                    if (next_group >= active_groups() || next_group == 0) begin
                        point_open = 1'b0;
                        next_group = '0;
                        if (point_passes) begin
                            if (accepted != COUNT_MAX) accepted = accepted + 1'b1;
                            res.result_id      = point_id;
                            res.result_score   = clip_add(run_score, point_bias);
                            res.accepted_count = accepted;
                            expected_scores = {expected_scores, res};
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Sample all three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            run_score    = '0;
            point_bias   = '0;
            next_group   = '0;
            point_id     = '0;
            point_passes = 1'b0;
            point_open   = 1'b0;
            accepted     = '0;
            threshold    = THRESH_RESET;
            groups_cfg   = GROUPS_RESET;
            expected_scores.delete();
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FILTER_THRESHOLD: threshold  = cfg_data[ID_W-1:0];
                    CFG_GROUPS_IN_USE:    groups_cfg = cfg_data[GROUP_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_item(s_data);
        end
        fail_count      <= errors;
        pending_results <= expected_scores.size();
    end

endmodule

[sim/pq_adc_filtered_scorer_unit_tb.sv]
// ----------------------------------------------------------------------------
// PQ ADC filtered scorer testbench
// Drives table loads, points and codes into the scorer under random idling on
// both channels and across several register settings, and lets the checker
// beside the block predict and compare every result.
// ----------------------------------------------------------------------------
module pq_adc_filtered_scorer_unit_tb;
    import pqadc_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         TARGET_ITEMS  = 1300;
    localparam int         CALM_ITEMS    = 1100;
    localparam int         PHASE_ITEMS   = 120;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         QUIET_LIMIT   = 1000;
    localparam int         GROUP_LIMIT   = 32;
    localparam int         LUT_DEPTH     = 8192;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    pqadc_in_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    pqadc_out_t             m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending_results;

    // Sender's view of the block, used to keep every table read on a loaded entry.
    bit        loaded [0:LUT_DEPTH-1];
    bit        pt_open    = 1'b0;
    int        pt_group   = 0;
    int        groups_eff = GROUPS_RESET;
    logic [ID_W-1:0] threshold = THRESH_RESET;
    int        items_sent = 0;
    bit        tx_gaps    = 1'b0;
    bit        rx_stalls  = 1'b0;
    int        quiet_cycles = 0;

    pq_adc_filtered_scorer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pq_adc_score_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Q16.16 values: half moderate, a quarter fully random, a quarter the extremes.
    function automatic logic signed [SCORE_W-1:0] pick_q16();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    // Point ids cluster around the filter threshold.
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] id;
        case ($urandom_range(0, 5))
            0:       id = threshold;
            1:       id = (threshold == 0) ? '0 : threshold - 1'b1;
            2:       id = 24'($urandom);
            3:       id = '1;
            4:       id = '0;
            default: id = (threshold > 24'hFFFF00) ? threshold
                                                   : threshold + 24'($urandom_range(1, 200));
        endcase
        return id;
    endfunction

    // Every field random; callers then set the ones the operation uses.
    function automatic pqadc_in_t noise_item();
        pqadc_in_t it;
        it.op            = 2'($urandom_range(0, 3));
        it.table_group   = 5'($urandom_range(0, 31));
        it.code          = 8'($urandom_range(0, 255));
        it.value         = $urandom;
        it.cluster_score = $urandom;
        it.point_id      = 24'($urandom);
        it.new_cluster   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one input transaction and wait until it is taken.
    task automatic push_item(input pqadc_in_t it);
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        case (it.op)
            OP_WRITE: loaded[{it.table_group, it.code}] = 1'b1;
            OP_BEGIN: begin
                pt_open  = 1'b1;
                pt_group = 0;
            end
            OP_CODE: begin
                if (pt_open) begin
                    pt_group++;
                    if (pt_group >= groups_eff) begin
                        pt_open  = 1'b0;
                        pt_group = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_write(input logic [TGROUP_W-1:0] g, input logic [CODE_W-1:0] c,
                              input logic signed [SCORE_W-1:0] v);
        pqadc_in_t it;
        it             = noise_item();
        it.op          = OP_WRITE;
        it.table_group = g;
        it.code        = c;
        it.value       = v;
        push_item(it);
    endtask

    task automatic send_begin(input logic [ID_W-1:0] id, input logic signed [SCORE_W-1:0] bias,
                              input logic signed [SCORE_W-1:0] cscore, input logic newc);
        pqadc_in_t it;
        it               = noise_item();
        it.op            = OP_BEGIN;
        it.point_id      = id;
        it.value         = bias;
        it.cluster_score = cscore;
        it.new_cluster   = newc;
        push_item(it);
    endtask

    task automatic send_random_begin();
        send_begin(pick_id(), pick_q16(), pick_q16(), $urandom_range(0, 3) == 0);
    endtask

    // A code for the open point first loads its table entry if that is still empty.
    task automatic send_code(input logic [CODE_W-1:0] c);
        pqadc_in_t it;
        it      = noise_item();
        it.op   = OP_CODE;
        it.code = c;
        if (pt_open && !loaded[{5'(pt_group), c}]) send_write(5'(pt_group), c, pick_q16());
        push_item(it);
    endtask

    task automatic send_junk();
        pqadc_in_t it;
        it    = noise_item();
        it.op = OP_UNUSED;
        push_item(it);
    endtask

    // Hold the sender until every predicted result has come out.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        int g;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_FILTER_THRESHOLD) begin
            threshold = data[ID_W-1:0];
        end else if (idx == CFG_GROUPS_IN_USE) begin
            g = data[GROUP_CNT_W-1:0];
            if (g == 0) g = 1;
            if (g > GROUP_LIMIT) g = GROUP_LIMIT;
            groups_eff = g;
        end
    endtask

    // Both registers are written once the block has gone quiet; unused bits are noise.
    task automatic configure(input logic [ID_W-1:0] thr, input logic [GROUP_CNT_W-1:0] grp);
        drain();
        write_reg(CFG_FILTER_THRESHOLD, {8'($urandom), thr});
        write_reg(CFG_GROUPS_IN_USE, {26'($urandom), grp});
        cfg_valid <= 1'b0;
    endtask

    // Result side: ready with random stall bursts.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (rx_stalls && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAIL pq_adc_filtered_scorer_unit");
            $finish;
        end
    end

    initial begin
        int                     pick;
        int                     phase;
        int                     phase_end;
        logic [GROUP_CNT_W-1:0] grp_setting;
        logic [ID_W-1:0]        thr_setting;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FILTER_THRESHOLD;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored items, extreme table values and scores, filter edges.
        send_code(8'hFF);
        send_junk();
        send_write(5'd0, 8'd0, 32'sh7FFF_FFFF);
        send_write(5'd0, 8'd255, 32'sh8000_0000);
        send_write(5'd1, 8'd0, 32'sh0001_0000);
        send_write(5'd1, 8'd255, -32'sd1);
        configure(24'h000010, 6'd2);
        send_begin(24'h000010, 32'sh7FFF_FFFF, 32'sh7FFF_0000, 1'b1);
        send_code(8'd0);
        send_code(8'd255);
        send_begin(24'h00000F, 32'sh0, 32'sh0, 1'b0);
        send_code(8'd0);
        send_code(8'd0);
        send_begin(24'hFFFFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_code(8'd255);
        send_code(8'd255);
        // A new begin abandons the open point.
        send_begin(24'h000020, 32'sh1, 32'sh2, 1'b0);
        send_code(8'd0);
        send_begin(24'h000021, 32'sh3, 32'sh4, 1'b0);
        send_code(8'd255);
        send_code(8'd0);
        // The group count drops below the groups already taken by an open point.
        configure(24'h000000, 6'd4);
        send_begin(24'h000005, 32'sh10, 32'sh20, 1'b1);
        send_code(8'd1);
        send_code(8'd2);
        send_code(8'd3);
        configure(24'h000000, 6'd2);
        send_code(8'd7);

        // Random phases, each under its own register setting.
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        phase     = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (phase % 6)
                0:       grp_setting = 6'd1;
                1:       grp_setting = 6'd0;
                2:       grp_setting = 6'd32;
                3:       grp_setting = 6'd63;
                default: grp_setting = 6'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       thr_setting = '0;
                1:       thr_setting = '1;
                default: thr_setting = 24'($urandom);
            endcase
            configure(thr_setting, grp_setting);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < TARGET_ITEMS) begin
                if (items_sent >= CALM_ITEMS) begin
                    tx_gaps   = 1'b0;
                    rx_stalls = 1'b0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_random_begin();
                    repeat (groups_eff) send_code(8'($urandom_range(0, 255)));
                end else if (pick < 80) begin
                    send_random_begin();
                    repeat ($urandom_range(0, groups_eff - 1))
                        send_code(8'($urandom_range(0, 255)));
                end else if (pick < 88) begin
                    send_code(8'($urandom_range(0, 255)));
                end else if (pick < 93) begin
                    send_write(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                               pick_q16());
                end else if (pick < 96) begin
                    send_junk();
                end else begin
                    drain();
                end
            end
            phase++;
        end

        // Let the last results come out, then give the verdict.
        drain();
        repeat (12) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS pq_adc_filtered_scorer_unit");
        else
            $display("FAIL pq_adc_filtered_scorer_unit");
        $finish;
    end

endmodule
